// ===== sv/segment_triangle_hit_test_macros.svh =====
// ----------------------------------------------------------------------------
// Segment triangle hit test assertion macros
// Shared concurrent assertion wrappers for the hit test RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_HIT_TEST_MACROS_SVH
`define SEGMENT_TRIANGLE_HIT_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define STH_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sth assertion failed");
// next-cycle implication
`define STH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sth assertion failed");
`else
`define STH_ASSERT_NOW(name, clk, rst, ante, cons)
`define STH_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sth_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment triangle hit test package
// Shared constants and pipeline control types.
// ----------------------------------------------------------------------------
package sth_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int FIELD_BITS = 48;
   localparam int NUM_STAGES = 6;

   // cyclic component order for cross products
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctrl_type;

endpackage

// ===== sv/sth_datapath.sv =====
// ----------------------------------------------------------------------------
// Segment triangle hit test datapath
// Six register stages: differences, products, cross sums, products, dot sums,
// and the final side and edge decision.
// ----------------------------------------------------------------------------
module sth_datapath #(
   parameter int COORD_BITS = sth_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  sth_pkg::stage_ctrl_type        ctrl,
   input  logic [sth_pkg::FIELD_BITS-1:0] vertex_a,
   input  logic [sth_pkg::FIELD_BITS-1:0] vertex_b,
   input  logic [sth_pkg::FIELD_BITS-1:0] vertex_c,
   input  logic [sth_pkg::FIELD_BITS-1:0] seg_start,
   input  logic [sth_pkg::FIELD_BITS-1:0] seg_end,
   output logic                           hit,
   output logic                           degenerate
);

   localparam int C    = COORD_BITS;
   localparam int W1   = C + 1;
   localparam int W2P  = 2 * C + 2;
   localparam int W2   = 2 * C + 3;
   localparam int W3P  = 3 * C + 4;
   localparam int W3   = 3 * C + 6;
   localparam int PACK = 3 * C;
   localparam int EXT  = PACK + sth_pkg::FIELD_BITS;

   // unpacked coordinates
   logic signed [C-1:0] pt_in [5][3];
   logic [EXT-1:0]      ext_in [5];

   // stage 1: edge and point differences
   logic signed [W1-1:0] edge_in [3][3], sv_in [3][3], ev_in [3][3], eac_in [3];
   logic signed [W1-1:0] edge1_ff [3][3], sv1_ff [3][3], ev1_ff [3][3], eac1_ff [3];

   // stage 2: partial products
   logic signed [W2P-1:0] np_in [3][2], wp_in [3][3][2];
   logic signed [W2P-1:0] np2_ff [3][2], wp2_ff [3][3][2];
   logic signed [W1-1:0]  edge2_ff [3][3], ws2_ff [3], we2_ff [3];

   // stage 3: normal and per-edge cross products
   logic signed [W2-1:0] n_in [3], w_in [3][3];
   logic signed [W2-1:0] n3_ff [3], w3_ff [3][3];
   logic signed [W1-1:0] edge3_ff [3][3], ws3_ff [3], we3_ff [3];

   // stage 4: dot products, terms
   logic signed [W3P-1:0] dap_in [3], dbp_in [3], gp_in [3][3];
   logic signed [W3P-1:0] dap4_ff [3], dbp4_ff [3], gp4_ff [3][3];

   // stage 5: sums
   logic signed [W3-1:0] da_in, db_in, g_in [3];
   logic signed [W3-1:0] da5_ff, db5_ff, g5_ff [3];

   // stage 6: decision
   logic hit_in, degen_in, hit6_ff, degen6_ff;
   logic da_neg, da_zero, db_neg, db_zero, same_side, plane_a;
   logic [2:0] edge_ok;

   always_comb begin
      ext_in[0] = {{PACK{1'b0}}, vertex_a};
      ext_in[1] = {{PACK{1'b0}}, vertex_b};
      ext_in[2] = {{PACK{1'b0}}, vertex_c};
      ext_in[3] = {{PACK{1'b0}}, seg_start};
      ext_in[4] = {{PACK{1'b0}}, seg_end};
      for (int p = 0; p < 5; p++) begin
         for (int i = 0; i < 3; i++) begin
            pt_in[p][i] = ext_in[p][i*C +: C];
         end
      end
      for (int i = 0; i < 3; i++) begin
         // edges A->B, B->C, C->A with start vertex k
         for (int k = 0; k < 3; k++) begin
            edge_in[k][i] = W1'(pt_in[sth_pkg::NXT[k]][i]) - W1'(pt_in[k][i]);
            sv_in[k][i]   = W1'(pt_in[3][i]) - W1'(pt_in[k][i]);
            ev_in[k][i]   = W1'(pt_in[4][i]) - W1'(pt_in[k][i]);
         end
         eac_in[i] = W1'(pt_in[2][i]) - W1'(pt_in[0][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         edge1_ff <= edge_in;
         sv1_ff   <= sv_in;
         ev1_ff   <= ev_in;
         eac1_ff  <= eac_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         np_in[i][0] = W2P'(edge1_ff[0][sth_pkg::NXT[i]]) * W2P'(eac1_ff[sth_pkg::PRV[i]]);
         np_in[i][1] = W2P'(edge1_ff[0][sth_pkg::PRV[i]]) * W2P'(eac1_ff[sth_pkg::NXT[i]]);
         for (int k = 0; k < 3; k++) begin
            wp_in[k][i][0] = W2P'(ev1_ff[k][sth_pkg::NXT[i]]) * W2P'(sv1_ff[k][sth_pkg::PRV[i]]);
            wp_in[k][i][1] = W2P'(ev1_ff[k][sth_pkg::PRV[i]]) * W2P'(sv1_ff[k][sth_pkg::NXT[i]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         np2_ff   <= np_in;
         wp2_ff   <= wp_in;
         edge2_ff <= edge1_ff;
         ws2_ff   <= sv1_ff[0];
         we2_ff   <= ev1_ff[0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = W2'(np2_ff[i][0]) - W2'(np2_ff[i][1]);
         for (int k = 0; k < 3; k++) begin
            w_in[k][i] = W2'(wp2_ff[k][i][0]) - W2'(wp2_ff[k][i][1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         n3_ff    <= n_in;
         w3_ff    <= w_in;
         edge3_ff <= edge2_ff;
         ws3_ff   <= ws2_ff;
         we3_ff   <= we2_ff;
      end
   end

   // edge . ((E-V) x (S-V)) carries the edge test sign up to the plane side
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dap_in[i] = W3P'(ws3_ff[i]) * W3P'(n3_ff[i]);
         dbp_in[i] = W3P'(we3_ff[i]) * W3P'(n3_ff[i]);
         for (int k = 0; k < 3; k++) begin
            gp_in[k][i] = W3P'(edge3_ff[k][i]) * W3P'(w3_ff[k][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         dap4_ff <= dap_in;
         dbp4_ff <= dbp_in;
         gp4_ff  <= gp_in;
      end
   end

   always_comb begin
      da_in = W3'(dap4_ff[0]) + W3'(dap4_ff[1]) + W3'(dap4_ff[2]);
      db_in = W3'(dbp4_ff[0]) + W3'(dbp4_ff[1]) + W3'(dbp4_ff[2]);
      for (int k = 0; k < 3; k++) begin
         g_in[k] = W3'(gp4_ff[k][0]) + W3'(gp4_ff[k][1]) + W3'(gp4_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         da5_ff <= da_in;
         db5_ff <= db_in;
         g5_ff  <= g_in;
      end
   end

   always_comb begin
      da_neg    = da5_ff[W3-1];
      db_neg    = db5_ff[W3-1];
      da_zero   = (da5_ff == '0);
      db_zero   = (db5_ff == '0);
      same_side = (!da_neg && !da_zero && !db_neg && !db_zero) || (da_neg && db_neg);
      degen_in  = da_zero && db_zero;
      // start side non-negative, end side non-positive: keep edge sign as is
      plane_a   = db_neg || (db_zero && !da_neg);
      for (int k = 0; k < 3; k++) begin
         edge_ok[k] = plane_a ? !g5_ff[k][W3-1] : (g5_ff[k][W3-1] || (g5_ff[k] == '0));
      end
      hit_in = !same_side && !degen_in && (&edge_ok);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         hit6_ff   <= hit_in;
         degen6_ff <= degen_in;
      end
   end

   assign hit        = hit6_ff;
   assign degenerate = degen6_ff;

endmodule

// ===== sv/segment_triangle_hit_test.sv =====
// ----------------------------------------------------------------------------
// Segment triangle hit test
// Streams one segment/triangle pair per word and reports hit and degenerate.
// ----------------------------------------------------------------------------
// Takes one word per cycle while req_stall is low. An accepted word passes
// in order through the six register stages, and rsp_valid rises when it
// reaches the last of them. The stages are the differences, two multiply
// levels each split into product and sum stages, and the decision register
// that also serves as the output register. Each stage advances whenever it
// is empty or the stage after it moves, so gaps close up under stall and
// input keeps flowing while a result waits, until every stage is full.
module segment_triangle_hit_test #(
   parameter int COORD_BITS = sth_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sth_pkg::FIELD_BITS-1:0] req_vertex_a,
   input  logic [sth_pkg::FIELD_BITS-1:0] req_vertex_b,
   input  logic [sth_pkg::FIELD_BITS-1:0] req_vertex_c,
   input  logic [sth_pkg::FIELD_BITS-1:0] req_seg_start,
   input  logic [sth_pkg::FIELD_BITS-1:0] req_seg_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic                           rsp_degenerate
);

`include "segment_triangle_hit_test_macros.svh"

   localparam int NS = sth_pkg::NUM_STAGES;

   logic [NS-1:0] valid_ff, valid_in, adv;
   sth_pkg::stage_ctrl_type ctrl;

   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign ctrl.load = adv;
   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NS-1];

   sth_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .ctrl       (ctrl),
      .vertex_a   (req_vertex_a),
      .vertex_b   (req_vertex_b),
      .vertex_c   (req_vertex_c),
      .seg_start  (req_seg_start),
      .seg_end    (req_seg_end),
      .hit        (rsp_hit),
      .degenerate (rsp_degenerate)
   );

   `STH_ASSERT_NOW(a_no_stall_flows, clock, reset, !rsp_stall, !req_stall)
   `STH_ASSERT_NOW(a_full_stalls, clock, reset, (&valid_ff) && rsp_stall, req_stall)
   `STH_ASSERT_NOW(a_degen_no_hit, clock, reset, rsp_valid && rsp_degenerate, !rsp_hit)
   `STH_ASSERT_NEXT(a_stalled_kept, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule
